// ===== rtl/longest_match_dfa_race_unit_macros.svh =====
// assertion macros for the longest match dfa race unit
`ifndef LONGEST_MATCH_DFA_RACE_UNIT_MACROS_SVH
`define LONGEST_MATCH_DFA_RACE_UNIT_MACROS_SVH

// consequent must hold in the same cycle
`define LMDFA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the following cycle
`define LMDFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lmdfa_pkg.sv =====
// package with codes, widths and the result type of the longest match dfa race unit
`default_nettype none

package lmdfa_pkg;

    localparam int FUNC_W       = 3;
    localparam int SLOT_W       = 2;
    localparam int STATE_W      = 8;
    localparam int TOKEN_W      = 4;
    localparam int VALUE_W      = 8;
    localparam int BYTE_W       = 8;
    localparam int LEN_W        = 16;
    localparam int ENABLE_W     = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 8;

    // address space reachable through the item fields
    localparam int SLOT_SPACE   = 4;
    localparam int STATE_SPACE  = 256;
    localparam int TOKEN_SPACE  = 16;
    localparam int BYTE_SPACE   = 256;

    localparam logic [FUNC_W-1:0] FUNC_LOAD_TRANS  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_CLASS  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_ACCEPT = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_TEXT        = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_END         = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_DFA_ENABLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_STATE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REJECT_STATE = 2'd2;

    localparam logic [ENABLE_W-1:0] ENABLE_RESET = 4'hF;
    localparam logic [STATE_W-1:0]  START_RESET  = 8'd1;
    localparam logic [STATE_W-1:0]  REJECT_RESET = 8'd0;

    localparam logic [LEN_W-1:0] LEN_MAX = 16'hFFFF;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] winner;
        logic [LEN_W-1:0]  length;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/longest_match_dfa_race_unit.sv =====
// top level of the longest match dfa race unit: per-slot table memories and match tracking
//
//  channel | direction | handshake                 | beat contents
//  --------+-----------+---------------------------+----------------------------------------
//  in      | input     | i_in_valid / o_in_stall   | func, dfa_index, state_index, token,
//          |           |                           | load_value, char_byte
//  out     | output    | o_out_valid / i_out_stall | match_found, winner, match_length
//  cfg     | input     | i_cfg_we                  | i_cfg_index, i_cfg_data
//
//  loads write the selected slot's memory as they are taken; a text byte goes through the class
//  read followed by the transition read in each slot's memories, the next state feeding the
//  accept read of the following byte; end of text goes through the class and accept reads
//  reset is synchronous; tables are undefined until loaded and get no clearing pass
//  results go through an output register and one skid entry; the input stalls while a text
//  byte or end of text is still in its reads and while the skid entry holds a result
`default_nettype none

`include "longest_match_dfa_race_unit_macros.svh"

module longest_match_dfa_race_unit
    import lmdfa_pkg::*;
#(
    parameter int NUM_DFAS    = 4,
    parameter int STATE_COUNT = 256,
    parameter int TOKEN_COUNT = 16,
    parameter int POS_WIDTH   = 16
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  wire  [FUNC_W-1:0]     i_func,
    input  wire  [SLOT_W-1:0]     i_dfa_index,
    input  wire  [STATE_W-1:0]    i_state_index,
    input  wire  [TOKEN_W-1:0]    i_token_index,
    input  wire  [VALUE_W-1:0]    i_load_value,
    input  wire  [BYTE_W-1:0]     i_char_byte,
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output logic                  o_match_found,
    output logic [SLOT_W-1:0]     o_winner,
    output logic [LEN_W-1:0]      o_match_length,
    input  wire                   i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int LANES     = (NUM_DFAS > SLOT_SPACE) ? SLOT_SPACE : NUM_DFAS;
    localparam int ST_USED   = (STATE_COUNT > STATE_SPACE) ? STATE_SPACE : STATE_COUNT;
    localparam int TK_USED   = (TOKEN_COUNT > TOKEN_SPACE) ? TOKEN_SPACE : TOKEN_COUNT;
    localparam int QW        = $clog2(ST_USED);
    localparam int TW        = $clog2(TK_USED);
    localparam int TR_DEPTH  = 1 << (QW + TW);
    localparam int ACC_DEPTH = 1 << QW;

    logic                  w_in_acc;
    logic                  w_is_text;
    logic                  w_is_end;
    logic                  w_rd_issue;
    logic                  w_out_take;

    logic [ENABLE_W-1:0]   r_enable;
    logic [STATE_W-1:0]    r_start;
    logic [STATE_W-1:0]    r_reject;
    logic [ENABLE_W-1:0]   n_enable;
    logic [STATE_W-1:0]    n_start;
    logic [STATE_W-1:0]    n_reject;
    logic                  n_rearm;

    logic [STATE_W-1:0]    r_state [LANES];
    logic [LANES-1:0]      r_take_tr;
    logic [LANES-1:0]      r_dead;
    logic [POS_WIDTH-1:0]  r_pos;
    logic [POS_WIDTH-1:0]  r_best;
    logic [SLOT_W-1:0]     r_slot;
    logic                  r_any;

    logic                  r_busy;
    logic                  r_stage_text;
    logic                  r_stage_end;

    logic [LANES-1:0]      n_dead;
    logic [POS_WIDTH-1:0]  n_best;
    logic [SLOT_W-1:0]     n_slot;
    logic                  n_any;

    logic [STATE_W-1:0]    w_cur_state [LANES];
    logic [STATE_W-1:0]    w_tr_rd     [LANES];
    logic [LANES-1:0]      w_acc_rd;
    logic [LANES-1:0]      w_st_ok;
    logic [LANES-1:0]      w_tk_ok;
    logic [LANES-1:0]      w_tr_re;

    t_result               w_result;
    t_result               r_out;
    t_result               r_skid;
    logic                  r_ovalid;
    logic                  r_svalid;

    assign o_in_stall = r_busy || r_svalid;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_is_text  = w_in_acc && (i_func == FUNC_TEXT);
    assign w_is_end   = w_in_acc && (i_func == FUNC_END);
    assign w_rd_issue = w_is_text || w_is_end;
    assign w_out_take = r_ovalid && !i_out_stall;

    genvar g;
    generate
        for (g = 0; g < LANES; g++) begin : g_lane
            logic [VALUE_W-1:0] r_trans_mem  [TR_DEPTH];
            logic [TOKEN_W-1:0] r_class_mem  [BYTE_SPACE];
            logic               r_accept_mem [ACC_DEPTH];
            logic [STATE_W-1:0] r_tr_rd;
            logic [TOKEN_W-1:0] r_cls_rd;
            logic               r_acc_rd;
            logic               w_sel;

            assign w_sel = w_in_acc && (i_dfa_index == SLOT_W'(g));

            always_ff @(posedge i_clk) begin
                if (w_sel && (i_func == FUNC_LOAD_TRANS) && (32'(i_state_index) < STATE_COUNT)
                        && (32'(i_token_index) < TOKEN_COUNT)) begin
                    r_trans_mem[{i_state_index[QW-1:0], i_token_index[TW-1:0]}] <= i_load_value;
                end
                if (w_tr_re[g]) begin
                    r_tr_rd <= r_trans_mem[{r_state[g][QW-1:0], r_cls_rd[TW-1:0]}];
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_sel && (i_func == FUNC_LOAD_CLASS)) begin
                    r_class_mem[i_char_byte] <= i_load_value[TOKEN_W-1:0];
                end
                if (w_rd_issue) begin
                    r_cls_rd <= r_class_mem[i_char_byte];
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_sel && (i_func == FUNC_LOAD_ACCEPT)
                        && (32'(i_state_index) < STATE_COUNT)) begin
                    r_accept_mem[i_state_index[QW-1:0]] <= i_load_value[0];
                end
                if (w_rd_issue) begin
                    r_acc_rd <= r_accept_mem[w_cur_state[g][QW-1:0]];
                end
            end

            // state of the last byte is still in the transition read register
            assign w_cur_state[g] = r_take_tr[g] ? r_tr_rd : r_state[g];
            assign w_tr_rd[g]     = r_tr_rd;
            assign w_acc_rd[g]    = r_acc_rd;
            assign w_st_ok[g]     = 32'(r_state[g]) < STATE_COUNT;
            assign w_tk_ok[g]     = 32'(r_cls_rd) < TOKEN_COUNT;
            assign w_tr_re[g]     = r_stage_text && !n_dead[g] && w_st_ok[g] && w_tk_ok[g];
        end
    endgenerate

    // liveness and accept check ahead of each byte and at end of text
    always_comb begin
        n_dead = r_dead;
        n_any  = r_any;
        n_best = r_best;
        n_slot = r_slot;
        for (int i = 0; i < LANES; i++) begin
            if (!r_dead[i]) begin
                if (r_state[i] == r_reject) begin
                    n_dead[i] = 1'b1;
                end else if (w_st_ok[i] && w_acc_rd[i]) begin
                    n_any  = 1'b1;
                    n_best = r_pos;
                    n_slot = SLOT_W'(i);
                end
            end
        end
    end

    always_comb begin
        w_result.found  = n_any;
        w_result.winner = n_any ? n_slot : '0;
        if (!n_any) begin
            w_result.length = '0;
        end else if (32'(n_best) > 32'(LEN_MAX)) begin
            w_result.length = LEN_MAX;
        end else begin
            w_result.length = LEN_W'(n_best);
        end
    end

    always_comb begin
        n_enable = r_enable;
        n_start  = r_start;
        n_reject = r_reject;
        n_rearm  = r_stage_end;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DFA_ENABLE: begin
                    n_enable = i_cfg_data[ENABLE_W-1:0];
                    n_rearm  = 1'b1;
                end
                CFG_START_STATE: begin
                    n_start = i_cfg_data;
                    n_rearm = 1'b1;
                end
                CFG_REJECT_STATE: begin
                    n_reject = i_cfg_data;
                    n_rearm  = 1'b1;
                end
                default: begin
                    n_rearm = r_stage_end;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable     <= ENABLE_RESET;
            r_start      <= START_RESET;
            r_reject     <= REJECT_RESET;
            for (int i = 0; i < LANES; i++) begin
                r_state[i] <= START_RESET;
                r_dead[i]  <= !ENABLE_RESET[i];
            end
            r_take_tr    <= '0;
            r_pos        <= '0;
            r_best       <= '0;
            r_slot       <= '0;
            r_any        <= 1'b0;
            r_busy       <= 1'b0;
            r_stage_text <= 1'b0;
            r_stage_end  <= 1'b0;
            r_ovalid     <= 1'b0;
            r_svalid     <= 1'b0;
        end else begin
            r_enable     <= n_enable;
            r_start      <= n_start;
            r_reject     <= n_reject;
            r_busy       <= w_rd_issue;
            r_stage_text <= w_is_text;
            r_stage_end  <= w_is_end;

            for (int i = 0; i < LANES; i++) begin
                if (r_take_tr[i]) begin
                    r_state[i]   <= w_tr_rd[i];
                    r_take_tr[i] <= 1'b0;
                end
            end

            if (r_stage_text) begin
                r_dead <= n_dead;
                r_any  <= n_any;
                r_best <= n_best;
                r_slot <= n_slot;
                for (int i = 0; i < LANES; i++) begin
                    if (!n_dead[i]) begin
                        if (w_st_ok[i] && w_tk_ok[i]) begin
                            r_take_tr[i] <= 1'b1;
                        end else begin
                            r_state[i] <= r_reject;
                        end
                    end
                end
                if (r_pos != '1) begin
                    r_pos <= r_pos + 1'b1;
                end
            end

            if (n_rearm) begin
                for (int i = 0; i < LANES; i++) begin
                    r_state[i] <= n_start;
                    r_dead[i]  <= !n_enable[i];
                end
                r_take_tr <= '0;
                r_pos     <= '0;
                r_best    <= '0;
                r_slot    <= '0;
                r_any     <= 1'b0;
            end

            // output register with one skid entry behind it
            if (r_stage_end) begin
                if (r_ovalid && !w_out_take) begin
                    r_svalid <= 1'b1;
                    r_skid   <= w_result;
                end else if (r_svalid) begin
                    r_out    <= r_skid;
                    r_ovalid <= 1'b1;
                    r_skid   <= w_result;
                end else begin
                    r_out    <= w_result;
                    r_ovalid <= 1'b1;
                end
            end else if (w_out_take) begin
                if (r_svalid) begin
                    r_out    <= r_skid;
                    r_svalid <= 1'b0;
                end else begin
                    r_ovalid <= 1'b0;
                end
            end
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_match_found  = r_out.found;
    assign o_winner       = r_out.winner;
    assign o_match_length = r_out.length;

    `LMDFA_ASSERT_NEXT(a_work_beat_blocks_input, w_rd_issue, o_in_stall, "input taken while busy")
    `LMDFA_ASSERT_NEXT(a_busy_single_cycle, r_busy, !r_busy, "busy longer than one cycle")
    `LMDFA_ASSERT_NEXT(a_end_gives_result, r_stage_end, o_out_valid, "end of text lost its result")
    `LMDFA_ASSERT_SAME(a_skid_behind_out, r_svalid, r_ovalid, "skid full with output empty")

endmodule

`default_nettype wire
